### rtl/sps_pkg.sv
// Shared types, constants and register map of the stepper position sequencer.
package sps_pkg;

	localparam int STEP_W = 16;
	localparam int FB_W = 12;
	localparam int SETTLE_W = 8;
	localparam int CORR_W = 8;
	localparam int WORD_W = 8;
	localparam int PHASE_W = 2;
	localparam int PHASE_COUNT = 4;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [WORD_W-1:0] STOP_WORD = 8'hff;
	localparam logic [WORD_W-1:0] IDLE_WORD = 8'h00;

	localparam logic [PHASE_W-1:0] PHASE_FIRST = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_LAST = 2'(PHASE_COUNT - 1);

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_TOLERANCE = 2'd0;
	localparam logic [1:0] REG_SETTLE = 2'd1;
	localparam logic [1:0] REG_CORRECTION = 2'd2;

	localparam logic [FB_W-1:0] TOLERANCE_RST = 12'd16;
	localparam logic [SETTLE_W-1:0] SETTLE_RST = 8'd25;
	localparam logic [CORR_W-1:0] CORRECTION_RST = 8'd15;

	typedef struct packed {
		logic [FB_W-1:0] tolerance;
		logic [SETTLE_W-1:0] settle_period;
		logic [CORR_W-1:0] correction_step;
	} cfg_t;

	// full-step drive pattern for each phase
	function automatic logic [WORD_W-1:0] phase_word(input logic [PHASE_W-1:0] phase);
		logic [WORD_W-1:0] w;
		case (phase)
			2'd0: w = 8'h1b;
			2'd1: w = 8'h13;
			2'd2: w = 8'h12;
			2'd3: w = 8'h1a;
			default: w = 8'h1b;
		endcase
		return w;
	endfunction

endpackage

### rtl/sps_regs.sv
// APB configuration registers of the stepper position sequencer.
module sps_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [sps_pkg::ADDR_W-1:0] paddr,
	input  logic [sps_pkg::DATA_W-1:0] pwdata,
	output logic [sps_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output sps_pkg::cfg_t             cfg
);
	import sps_pkg::*;

	cfg_t cfg_q;
	logic [1:0] reg_idx;
	logic wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	// write the addressed register on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance <= TOLERANCE_RST;
			cfg_q.settle_period <= SETTLE_RST;
			cfg_q.correction_step <= CORRECTION_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TOLERANCE: cfg_q.tolerance <= pwdata[FB_W-1:0];
				REG_SETTLE: cfg_q.settle_period <= pwdata[SETTLE_W-1:0];
				REG_CORRECTION: cfg_q.correction_step <= pwdata[CORR_W-1:0];
				default: ;
			endcase
		end
	end

	// read back, unmapped addresses read zero
	always_comb begin
		case (reg_idx)
			REG_TOLERANCE: prdata = DATA_W'(cfg_q.tolerance);
			REG_SETTLE: prdata = DATA_W'(cfg_q.settle_period);
			REG_CORRECTION: prdata = DATA_W'(cfg_q.correction_step);
			default: prdata = '0;
		endcase
	end

endmodule

### rtl/sps_core.sv
// Per-tick position update and registered result of the stepper position sequencer.
module sps_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sps_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sps_pkg::STEP_W-1:0]  target_step,
	input  logic [sps_pkg::FB_W-1:0]    target_feedback,
	input  logic [sps_pkg::FB_W-1:0]    measured_feedback,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sps_pkg::WORD_W-1:0]  drive_word,
	output logic                        drive_valid,
	output logic                        status
);
	import sps_pkg::*;

	logic [STEP_W-1:0] step_q, step_d;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [SETTLE_W-1:0] settle_q, settle_d, settle_inc;
	logic [WORD_W-1:0] word_d, word_q;
	logic dvalid_d, dvalid_q, status_d, status_q;
	logic out_valid_q;
	logic accept;
	logic [FB_W:0] got_plus_tol, want_plus_tol;
	logic fb_low, fb_high, can_lower;

	// take a new beat whenever the result register is empty or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	// feedback window, evaluated without wrap
	assign got_plus_tol = {1'b0, measured_feedback} + {1'b0, cfg.tolerance};
	assign want_plus_tol = {1'b0, target_feedback} + {1'b0, cfg.tolerance};
	assign fb_low = got_plus_tol < {1'b0, target_feedback};
	assign fb_high = {1'b0, measured_feedback} > want_plus_tol;
	assign can_lower = step_q > STEP_W'(cfg.correction_step);
	assign settle_inc = settle_q + 1'b1;

	// next position, phase and result for this tick
	always_comb begin
		step_d = step_q;
		phase_d = phase_q;
		settle_d = settle_q;
		word_d = IDLE_WORD;
		dvalid_d = 1'b0;
		status_d = 1'b0;
		if (step_q == target_step) begin
			if (settle_inc == cfg.settle_period) begin
				settle_d = '0;
				if (fb_low && can_lower) begin
					step_d = step_q - STEP_W'(cfg.correction_step);
				end else if (fb_high) begin
					step_d = step_q + STEP_W'(cfg.correction_step);
				end
			end else begin
				settle_d = settle_inc;
				word_d = STOP_WORD;
				dvalid_d = 1'b1;
				status_d = 1'b1;
			end
		end else if (step_q > target_step) begin
			phase_d = (phase_q == PHASE_FIRST) ? PHASE_LAST : phase_q - 1'b1;
			word_d = phase_word(phase_d);
			dvalid_d = 1'b1;
			step_d = step_q - 1'b1;
		end else begin
			phase_d = (phase_q == PHASE_LAST) ? PHASE_FIRST : phase_q + 1'b1;
			word_d = phase_word(phase_d);
			dvalid_d = 1'b1;
			step_d = step_q + 1'b1;
		end
	end

	// advance state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			phase_q <= '0;
			settle_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				step_q <= step_d;
				phase_q <= phase_d;
				settle_q <= settle_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until the receiver takes it
	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= word_d;
			dvalid_q <= dvalid_d;
			status_q <= status_d;
		end
	end

	assign out_valid = out_valid_q;
	assign drive_word = word_q;
	assign drive_valid = dvalid_q;
	assign status = status_q;

endmodule

### rtl/stepper_position_sequencer.sv
// Top level of the stepper position sequencer: register port and step core.
//
// Input channel (in_valid/in_ready) carries one control tick per beat:
// target_step, target_feedback and measured_feedback. Output channel
// (out_valid/out_ready) returns exactly one result beat per input beat:
// drive_word, drive_valid and status.
// The result of an accepted beat is registered: it is in the result register
// right after the edge that accepts the beat, ready to be taken from there.
// Throughput is one beat per cycle while the receiver takes results; the step counter, phase and settle
// counter update in one pass of compare and add logic ahead of the result
// register.
// When the receiver stalls, the result register holds its beat and
// in_ready drops while that register is full and not being drained, so at
// most one result waits and no beat is lost.
// Reset clears step counter, phase and settle counter, empties the result
// register and loads the configuration registers with their defaults
// (tolerance 16, settle period 25, correction step 15). The user is to write the APB
// port (registers at byte addresses 0, 4, 8) only while idle; the block does not enforce it.
module stepper_position_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sps_pkg::ADDR_W-1:0]  paddr,
	input  logic [sps_pkg::DATA_W-1:0]  pwdata,
	output logic [sps_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sps_pkg::STEP_W-1:0]  target_step,
	input  logic [sps_pkg::FB_W-1:0]    target_feedback,
	input  logic [sps_pkg::FB_W-1:0]    measured_feedback,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sps_pkg::WORD_W-1:0]  drive_word,
	output logic                        drive_valid,
	output logic                        status
);
	import sps_pkg::*;

	cfg_t cfg;

	// configuration registers
	sps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// position update and result register
	sps_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.target_step       (target_step),
		.target_feedback   (target_feedback),
		.measured_feedback (measured_feedback),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.drive_word        (drive_word),
		.drive_valid       (drive_valid),
		.status            (status)
	);

endmodule

### bench/tb_stepper_position_sequencer.sv
// Self-checking testbench of the stepper position sequencer: step, settle and correction paths.
module tb_stepper_position_sequencer;

	timeunit 1ns;
	timeprecision 1ps;

	import sps_pkg::*;

	localparam int CLK_HALF = 2;
	localparam int RESET_CYCLES = 7;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int DWELL_CAP = 900;
	localparam int TAIL_CYCLES = 4;
	localparam int FB_MAX = 4095;
	localparam int STEP_MAX = 65535;
	localparam logic [WORD_W-1:0] FULL_STEP [PHASE_COUNT] = '{8'h1b, 8'h13, 8'h12, 8'h1a};

	typedef struct packed {
		logic [STEP_W-1:0] target;
		logic [FB_W-1:0] want_fb;
		logic [FB_W-1:0] got_fb;
	} tick_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic valid;
		logic status;
	} drive_beat_t;

	typedef struct packed {
		logic [STEP_W-1:0] step_count;
		logic [PHASE_W-1:0] phase;
		logic [SETTLE_W-1:0] settle;
	} motor_state_t;

	typedef struct packed {
		motor_state_t state;
		drive_beat_t beat;
	} tick_outcome_t;

	typedef enum int {FB_INSIDE, FB_LOW, FB_HIGH, FB_EDGE, FB_ANY} fb_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [STEP_W-1:0] target_step = '0;
	logic [FB_W-1:0] target_feedback = '0;
	logic [FB_W-1:0] measured_feedback = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [WORD_W-1:0] drive_word;
	logic drive_valid;
	logic status;

	// predictor copy (advanced on accepted beats) and planning copy (advanced as items are queued)
	motor_state_t motor_now = '0;
	motor_state_t plan_state = '0;
	cfg_t motor_cfg = '{TOLERANCE_RST, SETTLE_RST, CORRECTION_RST};
	cfg_t plan_cfg = '{TOLERANCE_RST, SETTLE_RST, CORRECTION_RST};

	tick_t pending_ticks [$];
	drive_beat_t expected_drive [$];

	bit calm = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int mismatches = 0;
	int ticks_sent = 0;
	int beats_checked = 0;
	int feedback_checks = 0;
	int stop_words = 0;
	int settings_loaded = 0;
	int quiet_cycles = 0;

	stepper_position_sequencer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.target_step(target_step),
		.target_feedback(target_feedback),
		.measured_feedback(measured_feedback),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_word(drive_word),
		.drive_valid(drive_valid),
		.status(status)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// one control tick: walk toward the target, or settle and check the feedback
	function automatic tick_outcome_t next_tick(input motor_state_t st, input cfg_t cfg,
			input tick_t tk);
		tick_outcome_t r;
		int lower;
		int upper;
		r.state = st;
		r.beat = '{IDLE_WORD, 1'b0, 1'b0};
		lower = int'(tk.want_fb) - int'(cfg.tolerance);
		upper = int'(tk.want_fb) + int'(cfg.tolerance);
		if (st.step_count == tk.target) begin
			r.state.settle = st.settle + 8'd1;
			if (r.state.settle == cfg.settle_period) begin
				if (int'(tk.got_fb) < lower && st.step_count > STEP_W'(cfg.correction_step))
					r.state.step_count = st.step_count - STEP_W'(cfg.correction_step);
				else if (int'(tk.got_fb) > upper)
					r.state.step_count = st.step_count + STEP_W'(cfg.correction_step);
				r.state.settle = '0;
			end else begin
				r.beat = '{STOP_WORD, 1'b1, 1'b1};
			end
		end else if (st.step_count > tk.target) begin
			r.state.phase = (st.phase == PHASE_FIRST) ? PHASE_LAST : st.phase - 2'd1;
			r.beat = '{FULL_STEP[r.state.phase], 1'b1, 1'b0};
			r.state.step_count = st.step_count - 16'd1;
		end else begin
			r.state.phase = (st.phase == PHASE_LAST) ? PHASE_FIRST : st.phase + 2'd1;
			r.beat = '{FULL_STEP[r.state.phase], 1'b1, 1'b0};
			r.state.step_count = st.step_count + 16'd1;
		end
		return r;
	endfunction

	// feedback pair placed relative to the tolerance window
	function automatic tick_t make_tick(input logic [STEP_W-1:0] tgt, input fb_mode_t mode);
		int tol;
		int want;
		int got;
		int pick;
		tol = int'(plan_cfg.tolerance);
		want = $urandom_range(0, FB_MAX);
		got = $urandom_range(0, FB_MAX);
		case (mode)
			FB_INSIDE: begin
				got = want - tol + int'($urandom_range(0, 2 * tol));
			end
			FB_LOW: begin
				if (tol < FB_MAX) begin
					want = $urandom_range(tol + 1, FB_MAX);
					got = $urandom_range(0, want - tol - 1);
				end
			end
			FB_HIGH: begin
				if (tol < FB_MAX) begin
					want = $urandom_range(0, FB_MAX - tol - 1);
					got = $urandom_range(want + tol + 1, FB_MAX);
				end
			end
			FB_EDGE: begin
				pick = $urandom_range(0, 3);
				got = want + ((pick < 2) ? -tol - 1 + pick : tol + pick - 2);
			end
			default: ;
		endcase
		if (got < 0)
			got = 0;
		if (got > FB_MAX)
			got = FB_MAX;
		return '{tgt, FB_W'(want), FB_W'(got)};
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("error: %s got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// queue an item and advance the planning copy so later targets track the motor
	task automatic queue_tick(input tick_t tk, output logic was_check);
		tick_outcome_t r;
		r = next_tick(plan_state, plan_cfg, tk);
		plan_state = r.state;
		pending_ticks.push_back(tk);
		was_check = !r.beat.valid;
	endtask

	// hold one target until the motor has reached it and seen one or two feedback checks
	task automatic plan_dwell(input logic [STEP_W-1:0] tgt, input fb_mode_t mode, output int n);
		int checks;
		int goal;
		logic was_check;
		checks = 0;
		n = 0;
		goal = $urandom_range(1, 2);
		while (checks < goal && n < DWELL_CAP) begin
			queue_tick(make_tick(tgt, mode), was_check);
			if (was_check)
				checks++;
			n++;
		end
		repeat ($urandom_range(0, 3)) begin
			queue_tick(make_tick(tgt, mode), was_check);
			n++;
		end
	endtask

	task automatic plan_phase(input int quota);
		int planned;
		int kind;
		int pos;
		int n;
		logic was_check;
		fb_mode_t mode;
		planned = 0;
		while (planned < quota) begin
			kind = $urandom_range(0, 9);
			pos = int'(plan_state.step_count);
			mode = fb_mode_t'($urandom_range(0, 4));
			n = 0;
			if (kind <= 5)
				pos = pos + int'($urandom_range(0, 24)) - 12;
			else if (kind <= 7)
				pos = pos + int'($urandom_range(0, 800)) - 400;
			else if (kind == 9)
				pos = $urandom_range(0, int'(plan_cfg.correction_step) + 4);
			if (pos < 0)
				pos = 0;
			if (pos > STEP_MAX)
				pos = STEP_MAX;
			if (kind == 8) begin
				// noise: fully random ticks
				n = $urandom_range(1, 8);
				repeat (n) queue_tick(make_tick(STEP_W'($urandom_range(0, STEP_MAX)), FB_ANY),
						was_check);
			end else begin
				plan_dwell(STEP_W'(pos), mode, n);
			end
			planned += n;
		end
	endtask

	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [DATA_W-1:0] data,
			output logic [DATA_W-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// write one register with junk above its width, then read it back
	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value, input int width);
		logic [DATA_W-1:0] rdata;
		logic [DATA_W-1:0] junk;
		junk = $urandom;
		apb_access(1'b1, idx, (junk << width) | value, rdata);
		apb_access(1'b0, idx, '0, rdata);
		if (rdata !== value)
			flag_mismatch($sformatf("register %0d readback", idx), rdata, value);
	endtask

	task automatic load_settings(input logic [FB_W-1:0] tol, input logic [SETTLE_W-1:0] settle,
			input logic [CORR_W-1:0] corr);
		write_reg(REG_TOLERANCE, DATA_W'(tol), FB_W);
		write_reg(REG_SETTLE, DATA_W'(settle), SETTLE_W);
		write_reg(REG_CORRECTION, DATA_W'(corr), CORR_W);
		motor_cfg = '{tol, settle, corr};
		plan_cfg = motor_cfg;
		settings_loaded++;
	endtask

	// drive input beats from the pending queue; predict on each accepted beat
	always @(posedge clk) begin : drive_ticks
		tick_t nxt_tick;
		logic nxt_valid;
		tick_outcome_t r;
		nxt_valid = in_valid;
		nxt_tick = '{target_step, target_feedback, measured_feedback};
		if (arst_n) begin
			if (in_valid && in_ready) begin
				r = next_tick(motor_now, motor_cfg, nxt_tick);
				motor_now = r.state;
				expected_drive.push_back(r.beat);
				ticks_sent++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_ticks.size() > 0) begin
					nxt_tick = pending_ticks.pop_front();
					nxt_valid = 1'b1;
					if (!calm && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(1, 6);
				end
			end
		end
		in_valid <= nxt_valid;
		target_step <= nxt_tick.target;
		target_feedback <= nxt_tick.want_fb;
		measured_feedback <= nxt_tick.got_fb;
	end

	// check each result beat against the oldest prediction; stall the receiver in bursts
	always @(posedge clk) begin : watch_drive
		drive_beat_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_drive.size() == 0) begin
					flag_mismatch("result beat with nothing expected, drive_word", drive_word, 0);
				end else begin
					want = expected_drive.pop_front();
					if (drive_word !== want.word)
						flag_mismatch("drive_word", drive_word, want.word);
					if (drive_valid !== want.valid)
						flag_mismatch("drive_valid", drive_valid, want.valid);
					if (status !== want.status)
						flag_mismatch("status", status, want.status);
					beats_checked++;
					if (!want.valid)
						feedback_checks++;
					if (want.status)
						stop_words++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// end the run when nothing moves on any port for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("watchdog: no beat for %0d cycles", WATCHDOG_CYCLES);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin : run_phases
		logic c;
		int quota;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 8; ph++) begin
			quota = 180;
			case (ph)
				0: begin
					// reset settings; directed extremes of position and feedback first
					queue_tick('{16'h0000, 12'h000, 12'h000}, c);
					queue_tick('{16'h0000, 12'hfff, 12'hfff}, c);
					queue_tick('{16'h0000, 12'h000, 12'hfff}, c);
					queue_tick('{16'h0000, 12'hfff, 12'h000}, c);
					repeat (5) queue_tick('{16'hffff, 12'haaa, 12'h555}, c);
					repeat (6) queue_tick('{16'h0000, 12'h555, 12'haaa}, c);
					queue_tick('{16'h0002, 12'h00f, 12'h000}, c);
					queue_tick('{16'h0001, 12'hff0, 12'hfff}, c);
					queue_tick('{16'h8000, 12'h800, 12'h7ff}, c);
					queue_tick('{16'h7fff, 12'h7ff, 12'h800}, c);
					queue_tick('{16'h0000, 12'h010, 12'h000}, c);
				end
				1: load_settings(12'd0, 8'd1, 8'd0);
				2: begin
					load_settings(12'd4095, 8'd255, 8'd255);
					quota = 300;
				end
				3: begin
					// settle period zero: check after 256 ticks at target
					load_settings(12'd5, 8'd0, 8'd1);
					quota = 300;
				end
				4: load_settings(FB_W'($urandom_range(0, 40)), SETTLE_W'($urandom_range(2, 8)),
						CORR_W'($urandom_range(200, 255)));
				default: begin
					calm = (ph == 7);
					load_settings(FB_W'($urandom_range(0, FB_MAX)), SETTLE_W'($urandom_range(1, 12)),
							CORR_W'($urandom_range(0, 255)));
				end
			endcase
			plan_phase(quota);
			// hold off until every beat of the phase is in and every result is out
			do @(negedge clk);
			while (pending_ticks.size() != 0 || in_valid || expected_drive.size() != 0);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d ticks under %0d register settings after reset values",
				ticks_sent, settings_loaded);
		$display("checked %0d result beats: %0d feedback checks, %0d stop words",
				beats_checked, feedback_checks, stop_words);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
